@@ design/spnd_pkg.sv @@
// Shared constants and round functions for the SPN block decryptor.
`default_nettype none

package spnd_pkg;

	typedef logic [15:0] block_t;
	typedef logic [31:0] key_t;

	localparam int unsigned NumRounds = 4;
	localparam key_t KeyReset = 32'h3A94D63F;

	// Invert the 4-bit S-box E4D12FB83A6C5907.
	function automatic logic [3:0] inv_sbox(input logic [3:0] nib);
		logic [3:0] res;
		case (nib)
			4'h0: res = 4'hE;
			4'h1: res = 4'h3;
			4'h2: res = 4'h4;
			4'h3: res = 4'h8;
			4'h4: res = 4'h1;
			4'h5: res = 4'hC;
			4'h6: res = 4'hA;
			4'h7: res = 4'hF;
			4'h8: res = 4'h7;
			4'h9: res = 4'hD;
			4'hA: res = 4'h9;
			4'hB: res = 4'h6;
			4'hC: res = 4'hB;
			4'hD: res = 4'h2;
			4'hE: res = 4'h0;
			4'hF: res = 4'h5;
			default: res = 4'h0;
		endcase
		return res;
	endfunction

	// Apply the inverse S-box to all four nibbles.
	function automatic block_t sub_inv(input block_t v);
		block_t res;
		for (int n = 0; n < 4; n++) begin
			res[4*n +: 4] = inv_sbox(v[4*n +: 4]);
		end
		return res;
	endfunction

	// Swap rows and columns of the 4x4 bit matrix; self-inverse.
	function automatic block_t transpose(input block_t v);
		block_t res;
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 4; b++) begin
				res[4*b + a] = v[4*a + b];
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

@@ design/spn_block_decrypt.sv @@
// Top level: key register and a chain of four round cells for SPN block decryption.
//
//  channel     signals                                 width  role
//  ---------   -------------------------------------   -----  -------------------
//  input       in_valid, in_ready, ciphertext          16     ciphertext word in
//  output      out_valid, out_ready, plaintext         16     plaintext word out
//  config      cfg_wr_en, cfg_wr_data                  32     cipher key write
//
// A word is registered once in each of the four round cells between acceptance and plaintext valid.
// A new word is accepted every cycle while the output is taken; the chain holds four.
// A stall at the output backs up cell by cell; a cell with a free slot still takes a word.
// Reset empties every cell and loads the cipher key with 0x3A94D63F.
`default_nettype none

module spn_block_decrypt (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire spnd_pkg::key_t   cfg_wr_data,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire spnd_pkg::block_t ciphertext,
	output logic                  out_valid,
	input  wire                   out_ready,
	output spnd_pkg::block_t      plaintext
);

	localparam int unsigned Cells = spnd_pkg::NumRounds;

	spnd_pkg::key_t   cipher_key_q;
	logic             valid_c [Cells+1];
	logic             ready_c [Cells+1];
	spnd_pkg::block_t data_c  [Cells+1];

	// Load the cipher key on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= spnd_pkg::KeyReset;
		end else if (cfg_wr_en) begin
			cipher_key_q <= cfg_wr_data;
		end
	end

	// Whiten with the last round key in front of the chain
	assign valid_c[0] = in_valid;
	assign data_c[0]  = ciphertext ^ cipher_key_q[15:0];
	assign in_ready   = ready_c[0];

	// Cell i decrypts round 4-i, key window at bits [19+4i : 4+4i]
	for (genvar i = 0; i < Cells; i++) begin : g_cell
		spnd_cell #(
			.Transpose (i != 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.round_key (cipher_key_q[19 + 4*i -: 16]),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_data   (data_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_data  (data_c[i+1])
		);
	end

	assign ready_c[Cells] = out_ready;
	assign out_valid      = valid_c[Cells];
	assign plaintext      = data_c[Cells];

endmodule

`default_nettype wire

@@ design/spnd_cell.sv @@
// One decryption round cell: optional transpose, inverse S-box, round key XOR, word register.
`default_nettype none

module spnd_cell #(
	parameter bit Transpose = 1'b1
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire spnd_pkg::block_t round_key,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire spnd_pkg::block_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output spnd_pkg::block_t     out_data
);

	logic             valid_q;
	spnd_pkg::block_t data_q;
	spnd_pkg::block_t mixed;
	spnd_pkg::block_t result;

	// Take a new word when empty or when the held word moves on
	assign in_ready = !valid_q || out_ready;

	// Round datapath
	always_comb begin
		mixed  = Transpose ? spnd_pkg::transpose(in_data) : in_data;
		result = spnd_pkg::sub_inv(mixed) ^ round_key;
	end

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Load the word; hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled word changed or dropped");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word not held");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !in_valid |=> !out_valid)
		else $error("word repeated after handoff");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the SPN block decryptor: directed table, then random words.
module tb_top;

	localparam int Latency = 4;
	localparam int WatchLimit = 1000;
	localparam int NumDir = 19;
	localparam int NumRand = 500;
	localparam int NumPhases = 5;

	// Inverse of the substitution E4D12FB83A6C5907
	localparam logic [3:0] InvSub [16] = '{
		4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
		4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
	};

	typedef struct packed {
		spnd_pkg::key_t   key;
		spnd_pkg::block_t ct;
		logic             known;
		spnd_pkg::block_t pt;
	} vec_t;

	// Directed rows; a typed plaintext is used only where it is easy to derive by hand
	vec_t dir_tab [NumDir] = '{
		'{spnd_pkg::KeyReset, 16'h0000, 1'b0, 16'h0000},
		'{spnd_pkg::KeyReset, 16'hFFFF, 1'b0, 16'h0000},
		'{spnd_pkg::KeyReset, 16'h8000, 1'b0, 16'h0000},
		'{spnd_pkg::KeyReset, 16'h0001, 1'b0, 16'h0000},
		'{spnd_pkg::KeyReset, 16'hA5A5, 1'b0, 16'h0000},
		'{spnd_pkg::KeyReset, 16'h5A5A, 1'b0, 16'h0000},
		'{spnd_pkg::KeyReset, 16'h1234, 1'b0, 16'h0000},
		'{32'h0000_0000,      16'hEEEE, 1'b1, 16'h3530},
		'{32'h0000_0000,      16'h0000, 1'b0, 16'h0000},
		'{32'h0000_0000,      16'hFFFF, 1'b0, 16'h0000},
		'{32'hFFFF_FFFF,      16'h1111, 1'b1, 16'h6163},
		'{32'hFFFF_FFFF,      16'h0000, 1'b0, 16'h0000},
		'{32'hFFFF_FFFF,      16'hFFFF, 1'b0, 16'h0000},
		'{32'h8000_0001,      16'h8001, 1'b0, 16'h0000},
		'{32'h8000_0001,      16'h7FFE, 1'b0, 16'h0000},
		'{32'h0000_0001,      16'h0000, 1'b0, 16'h0000},
		'{32'h8000_0000,      16'h0000, 1'b0, 16'h0000},
		'{32'h0F0F_0F0F,      16'h1234, 1'b0, 16'h0000},
		'{32'h0F0F_0F0F,      16'hEDCB, 1'b0, 16'h0000}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	spnd_pkg::key_t   cfg_wr_data;
	logic             in_valid;
	logic             in_ready;
	spnd_pkg::block_t ciphertext;
	logic             out_valid;
	logic             out_ready;
	spnd_pkg::block_t plaintext;

	spnd_pkg::key_t   key_now = spnd_pkg::KeyReset;
	spnd_pkg::block_t plain_q [$];
	bit     idle_on;
	int     n_sent;
	int     n_got;
	int     n_err;
	int     n_mism;
	int     n_keys;
	int     stall_cnt;

	spn_block_decrypt i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ciphertext (ciphertext),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.plaintext  (plaintext)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// 16-bit window of the key for round r (1..5); round 5 is the low half
	function automatic spnd_pkg::block_t round_key(input spnd_pkg::key_t k, input int r);
		return spnd_pkg::block_t'(k >> (20 - 4 * r));
	endfunction

	function automatic spnd_pkg::block_t undo_sub(input spnd_pkg::block_t v);
		spnd_pkg::block_t res;
		for (int n = 0; n < 4; n++) begin
			res[4*n +: 4] = InvSub[v[4*n +: 4]];
		end
		return res;
	endfunction

	// Swap rows and columns of the 4x4 bit matrix
	function automatic spnd_pkg::block_t flip_matrix(input spnd_pkg::block_t v);
		spnd_pkg::block_t res;
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 4; b++) begin
				res[4*b + a] = v[4*a + b];
			end
		end
		return res;
	endfunction

	function automatic spnd_pkg::block_t decrypt_block(input spnd_pkg::key_t k,
			input spnd_pkg::block_t ct);
		spnd_pkg::block_t w;
		w = undo_sub(ct ^ round_key(k, 5)) ^ round_key(k, 4);
		for (int r = 3; r >= 1; r--) begin
			w = undo_sub(flip_matrix(w)) ^ round_key(k, r);
		end
		return w;
	endfunction

	// Mix edge patterns into mostly uniform ciphertext
	function automatic spnd_pkg::block_t pick_block();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return spnd_pkg::block_t'(1) << $urandom_range(0, 15);
			3: return ~(spnd_pkg::block_t'(1) << $urandom_range(0, 15));
			default: return spnd_pkg::block_t'($urandom());
		endcase
	endfunction

	// Offer one word, hold it until taken, then queue its plaintext
	task automatic send_word(input spnd_pkg::block_t ct, input logic known,
			input spnd_pkg::block_t pt);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ciphertext <= ct;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		plain_q.push_back(known ? pt : decrypt_block(key_now, ct));
		n_sent++;
	endtask

	// Stop offering and wait for every queued plaintext
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (plain_q.size() != 0);
	endtask

	task automatic load_key(input spnd_pkg::key_t k);
		drain();
		repeat (Latency) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		key_now = k;
		n_keys++;
	endtask

	// Output side: ready runs broken by stall bursts while idling is on
	initial begin
		out_ready = 1'b0;
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (idle_on) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// Compare each plaintext word with the oldest prediction
	always @(posedge clk) begin : chk
		spnd_pkg::block_t want;
		if (arst_n && out_valid && out_ready) begin
			n_got++;
			if (plain_q.size() == 0) begin
				n_err++;
				n_mism++;
				if (n_mism <= 10) begin
					$display("plaintext mismatch: expected none got %h", plaintext);
				end
			end else begin
				want = plain_q.pop_front();
				if (plaintext !== want) begin
					n_err++;
					n_mism++;
					if (n_mism <= 10) begin
						$display("plaintext mismatch: expected %h got %h", want, plaintext);
					end
				end
			end
		end
	end

	// Abort when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cnt = 0;
		end else begin
			stall_cnt++;
		end
		if (stall_cnt >= WatchLimit) begin
			$display("watchdog: no word moved for %0d cycles", stall_cnt);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		vec_t row;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		ciphertext = '0;
		idle_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, loading a key whenever a row needs a new one
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			if (row.key != key_now) load_key(row.key);
			send_word(row.ct, row.known, row.pt);
		end

		// Random words under a fresh random key per phase; last phase without idling
		for (int p = 0; p < NumPhases; p++) begin
			load_key($urandom());
			if (p == NumPhases - 1) idle_on = 1'b0;
			for (int i = 0; i < NumRand / NumPhases; i++) begin
				if (p == 1 && i == NumRand / NumPhases / 2) drain();
				send_word(pick_block(), 1'b0, '0);
			end
		end

		// Let the pipeline empty, then settle
		drain();
		repeat (Latency * 2) @(posedge clk);
		n_err += plain_q.size();

		$display("run: %0d ciphertext words sent, %0d plaintext words checked, %0d key loads",
			n_sent, n_got, n_keys);
		$display("covered reset key, all-zero and all-one keys, edge blocks and random traffic");
		if (n_err == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d errors", n_err);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
